// ----- rtl/krf_pkg.sv -----
// krf_pkg: shared types, constants and helpers for the K-line receive framer.
// No dependencies; used by krf_in_if, krf_step and the top level.
package krf_pkg;

  localparam int MAX_MSG_LEN_DEF = 64;

  localparam int unsigned STATUS_BYTES   = 2;
  localparam int unsigned ISO_OVERHEAD   = 4;
  localparam int unsigned SHORT_OVERHEAD = 2;
  localparam logic [7:0]  LEN_MASK       = 8'h3F;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_ARM  = 1'b1
  } action_t;

  typedef struct packed {
    logic       accepted;
    logic [5:0] store_index;
    logic [6:0] received_count;
    logic [7:0] expected_length;
    logic       message_complete;
  } result_t;

  // Frame length from the header byte: ISO 14230 format when bit 7 is set.
  function automatic logic [7:0] frame_len(input logic [7:0] hdr);
    logic [7:0] len;
    if (hdr[7]) begin
      len = (hdr & LEN_MASK) + 8'(ISO_OVERHEAD);
    end else begin
      len = hdr + 8'(SHORT_OVERHEAD);
    end
    return len;
  endfunction

endpackage

// ----- rtl/krf_if.sv -----
// krf_in_if / krf_out_if: valid/ready channels for packet bytes and results.
// Depends on krf_pkg.
interface krf_in_if;
  import krf_pkg::*;
  logic       valid;
  logic       ready;
  action_t    action;
  logic [7:0] data_byte;
  logic [6:0] packet_length;
  logic [5:0] byte_position;
  logic [7:0] echo_count;

  modport source (output valid, action, data_byte, packet_length, byte_position, echo_count,
                  input ready);
  modport sink   (input valid, action, data_byte, packet_length, byte_position, echo_count,
                  output ready);
endinterface

interface krf_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [5:0] store_index;
  logic [6:0] received_count;
  logic [7:0] expected_length;
  logic       message_complete;

  modport source (output valid, accepted, store_index, received_count, expected_length,
                  message_complete, input ready);
  modport sink   (input valid, accepted, store_index, received_count, expected_length,
                  message_complete, output ready);
endinterface

// ----- rtl/krf_step.sv -----
// krf_step: per-beat framer logic; next state and result for one registered item.
// Depends on krf_pkg.
module krf_step #(
  parameter int MAX_MSG_LEN = krf_pkg::MAX_MSG_LEN_DEF,
  localparam int HW = $clog2(MAX_MSG_LEN + 1)
) (
  input  krf_pkg::action_t action,
  input  logic [7:0]       data_byte,
  input  logic [6:0]       packet_length,
  input  logic [5:0]       byte_position,
  input  logic [7:0]       echo_count,
  input  logic [HW-1:0]    held_r,
  input  logic [7:0]       echo_r,
  input  logic [7:0]       header_r,
  input  logic             chunk_acc_r,
  input  logic [6:0]       chunk_skip_r,
  output logic [HW-1:0]    held_nxt,
  output logic [7:0]       echo_nxt,
  output logic [7:0]       header_nxt,
  output logic             chunk_acc_nxt,
  output logic [6:0]       chunk_skip_nxt,
  output krf_pkg::result_t res
);
  import krf_pkg::*;

  localparam int SW = ((HW > 7) ? HW : 7) + 1;
  localparam int CW = (HW > 8) ? HW : 8;

  logic [6:0] pos_w;
  logic [6:0] serial;
  logic [6:0] skip;
  logic [6:0] rest;
  logic       pkt_ok;
  logic       store;
  logic       fits;
  logic       last_beat;
  logic [7:0] expect_len;

  always_comb begin
    pos_w  = {1'b0, byte_position};
    serial = packet_length - 7'(STATUS_BYTES);
    pkt_ok = (packet_length > 7'(STATUS_BYTES)) && (pos_w < packet_length);
    if ({1'b0, serial} <= echo_r) begin
      skip = serial;
    end else begin
      skip = echo_r[6:0];
    end
    rest = serial - skip;
    fits = (SW'(held_r) + SW'(rest)) <= SW'(MAX_MSG_LEN);
    last_beat = (pos_w == (packet_length - 7'd1));

    // stored bytes follow status and echo bytes; decision latched at position 0
    store = pkt_ok && (pos_w >= 7'(STATUS_BYTES)) &&
            ((pos_w - 7'(STATUS_BYTES)) >= chunk_skip_r) && chunk_acc_r &&
            (held_r < HW'(MAX_MSG_LEN));

    held_nxt       = held_r;
    echo_nxt       = echo_r;
    header_nxt     = header_r;
    chunk_acc_nxt  = chunk_acc_r;
    chunk_skip_nxt = chunk_skip_r;
    res            = '0;

    unique case (action)
      ACT_ARM: begin
        held_nxt       = '0;
        echo_nxt       = echo_count;
        chunk_acc_nxt  = 1'b0;
        chunk_skip_nxt = '0;
      end
      ACT_BYTE: begin
        if (pkt_ok && byte_position == '0) begin
          echo_nxt       = echo_r - {1'b0, skip};
          chunk_skip_nxt = skip;
          chunk_acc_nxt  = (rest != '0) && fits;
        end
        if (store) begin
          if (held_r == '0) header_nxt = data_byte;
          held_nxt        = held_r + HW'(1);
          res.accepted    = 1'b1;
          res.store_index = 6'(held_r);
        end
      end
      default: ;
    endcase

    expect_len = (held_nxt == '0) ? 8'd0 : frame_len(header_nxt);
    res.received_count   = 7'(held_nxt);
    res.expected_length  = expect_len;
    res.message_complete = (action == ACT_BYTE) && pkt_ok && last_beat &&
                           (held_nxt != '0) && (CW'(held_nxt) >= CW'(expect_len));
  end

endmodule

// ----- rtl/kline_receive_framer_unit.sv -----
// K-line receive framer: strips USB status and echo bytes, frames ISO 14230 messages.
// Pipeline: input register, then result register, from input beat to result beat.
// Throughput: one beat per cycle; input stalls only when both stages hold data and the
// result beat is not taken. The next state is computed by krf_step between the registers.
// Reset (rst_n low, synchronous): pipeline empty, count, echo, header and chunk
// state all zero.
module kline_receive_framer_unit #(
  parameter int MAX_MSG_LEN = krf_pkg::MAX_MSG_LEN_DEF
) (
  input  logic clk,
  input  logic rst_n,
  krf_in_if.sink    in_chan,
  krf_out_if.source out_chan
);
  import krf_pkg::*;

  localparam int HW = $clog2(MAX_MSG_LEN + 1);

  logic             s1_valid_r;
  action_t          s1_action_r;
  logic [7:0]       s1_data_r;
  logic [6:0]       s1_plen_r;
  logic [5:0]       s1_pos_r;
  logic [7:0]       s1_echo_r;

  logic [HW-1:0]    held_r,  held_nxt;
  logic [7:0]       echo_r,  echo_nxt;
  logic [7:0]       header_r, header_nxt;
  logic             chunk_acc_r, chunk_acc_nxt;
  logic [6:0]       chunk_skip_r, chunk_skip_nxt;

  logic             out_valid_r;
  result_t          out_res_r;
  result_t          step_res;

  logic             adv;
  logic             in_beat;

  assign adv     = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || adv;
  assign in_beat = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_action_r <= in_chan.action;
      s1_data_r   <= in_chan.data_byte;
      s1_plen_r   <= in_chan.packet_length;
      s1_pos_r    <= in_chan.byte_position;
      s1_echo_r   <= in_chan.echo_count;
    end
  end

  krf_step #(.MAX_MSG_LEN(MAX_MSG_LEN)) u_step (
    .action        (s1_action_r),
    .data_byte     (s1_data_r),
    .packet_length (s1_plen_r),
    .byte_position (s1_pos_r),
    .echo_count    (s1_echo_r),
    .held_r        (held_r),
    .echo_r        (echo_r),
    .header_r      (header_r),
    .chunk_acc_r   (chunk_acc_r),
    .chunk_skip_r  (chunk_skip_r),
    .held_nxt      (held_nxt),
    .echo_nxt      (echo_nxt),
    .header_nxt    (header_nxt),
    .chunk_acc_nxt (chunk_acc_nxt),
    .chunk_skip_nxt(chunk_skip_nxt),
    .res           (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      echo_r       <= '0;
      header_r     <= '0;
      chunk_acc_r  <= 1'b0;
      chunk_skip_r <= '0;
    end else if (adv) begin
      held_r       <= held_nxt;
      echo_r       <= echo_nxt;
      header_r     <= header_nxt;
      chunk_acc_r  <= chunk_acc_nxt;
      chunk_skip_r <= chunk_skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.accepted         = out_res_r.accepted;
  assign out_chan.store_index      = out_res_r.store_index;
  assign out_chan.received_count   = out_res_r.received_count;
  assign out_chan.expected_length  = out_res_r.expected_length;
  assign out_chan.message_complete = out_res_r.message_complete;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HW'(MAX_MSG_LEN))
    else $error("held count above message capacity");

  a_store_incr: assert property (@(posedge clk) disable iff (!rst_n)
    adv && step_res.accepted |-> held_nxt == held_r + HW'(1))
    else $error("stored byte did not advance the count");

  a_arm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_action_r == ACT_ARM |=> out_valid_r && out_res_r == '0)
    else $error("arm beat produced a nonzero result");

  a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.message_complete |-> out_res_r.expected_length != 8'd0)
    else $error("completion flagged without a frame length");

endmodule
